### rtl/srcd_pkg.sv
package srcd_pkg;

    // Job kinds passed from the decoder to the executor
    localparam logic [1:0] KIND_EMIT  = 2'd0;
    localparam logic [1:0] KIND_DUMP  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    // Result actions
    localparam logic [3:0] ACT_TX        = 4'd0;
    localparam logic [3:0] ACT_DIRECTION = 4'd1;
    localparam logic [3:0] ACT_SPEEDS    = 4'd2;
    localparam logic [3:0] ACT_BUZZER    = 4'd3;
    localparam logic [3:0] ACT_SERVO     = 4'd8;
    localparam logic [3:0] ACT_LCD       = 4'd9;

    // Open argument sequences
    localparam logic [3:0] PEND_NONE      = 4'd0;
    localparam logic [3:0] PEND_VELOCITY  = 4'd1;
    localparam logic [3:0] PEND_FORWARD   = 4'd2;
    localparam logic [3:0] PEND_BACK      = 4'd3;
    localparam logic [3:0] PEND_ROT_RIGHT = 4'd4;
    localparam logic [3:0] PEND_ROT_LEFT  = 4'd5;
    localparam logic [3:0] PEND_SERVO1    = 4'd6;
    localparam logic [3:0] PEND_SERVO2    = 4'd7;
    localparam logic [3:0] PEND_SERVO3    = 4'd8;
    localparam logic [3:0] PEND_LCD       = 4'd9;

    // Offsets from sequence code to action / servo number
    localparam logic [3:0] PEND_TO_MOVE_ACT = 4'd2;
    localparam logic [3:0] PEND_TO_SERVO    = 4'd5;

    // Command bytes
    localparam logic [7:0] CMD_FORWARD    = 8'h38;
    localparam logic [7:0] CMD_BACK       = 8'h32;
    localparam logic [7:0] CMD_RIGHT      = 8'h34;
    localparam logic [7:0] CMD_LEFT       = 8'h36;
    localparam logic [7:0] CMD_STOP       = 8'h35;
    localparam logic [7:0] CMD_BUZZ_ON    = 8'h37;
    localparam logic [7:0] CMD_BUZZ_OFF   = 8'h39;
    localparam logic [7:0] CMD_FULL_SPEED = 8'h53;
    localparam logic [7:0] CMD_IDENTITY   = 8'h6B;
    localparam logic [7:0] CMD_LEFT_LO    = 8'h72;
    localparam logic [7:0] CMD_LEFT_HI    = 8'h73;
    localparam logic [7:0] CMD_RIGHT_LO   = 8'h79;
    localparam logic [7:0] CMD_RIGHT_HI   = 8'h7A;
    localparam logic [7:0] CMD_SENSORS    = 8'h54;
    localparam logic [7:0] CMD_VELOCITY   = 8'h52;
    localparam logic [7:0] CMD_MOVE_FWD   = 8'h55;
    localparam logic [7:0] CMD_MOVE_BACK  = 8'h56;
    localparam logic [7:0] CMD_ROT_RIGHT  = 8'h57;
    localparam logic [7:0] CMD_ROT_LEFT   = 8'h58;
    localparam logic [7:0] CMD_SERVO1     = 8'h80;
    localparam logic [7:0] CMD_SERVO2     = 8'h81;
    localparam logic [7:0] CMD_SERVO3     = 8'h82;
    localparam logic [7:0] CMD_LCD        = 8'h83;

    // Direction nibbles
    localparam logic [7:0] DIR_FORWARD = 8'h06;
    localparam logic [7:0] DIR_BACK    = 8'h09;
    localparam logic [7:0] DIR_RIGHT   = 8'h0A;
    localparam logic [7:0] DIR_LEFT    = 8'h05;
    localparam logic [7:0] DIR_STOP    = 8'h00;

    localparam logic [7:0] FULL_SPEED   = 8'd255;
    localparam logic [7:0] FRAME_START  = 8'h59;
    localparam logic [7:0] FRAME_END    = 8'h5A;
    localparam logic [7:0] IDENTITY_RST = 8'd5;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  action;
        logic [7:0]  arg_a;
        logic [7:0]  arg_b;
        logic [7:0]  arg_c;
        logic [15:0] amount;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

### rtl/srcd_front.sv
module srcd_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 operation,
    input  logic [7:0]           rx_byte,
    input  logic [4:0]           sensor_slot,
    input  logic [7:0]           sensor_reading,
    input  logic [15:0]          left_pulses,
    input  logic [15:0]          right_pulses,
    input  logic                 cfg_valid,
    input  logic [7:0]           cfg_data,
    input  srcd_pkg::q_status_t  q_status,
    output logic                 push,
    output srcd_pkg::job_t       job
);

    logic [7:0]  identity_reg;
    logic [3:0]  pending_reg,  pending_next;
    logic [1:0]  pos_reg,      pos_next;
    logic [7:0]  first_reg,    first_next;
    logic [7:0]  second_reg,   second_next;
    logic [15:0] left_lat_reg, left_lat_next;
    logic [15:0] right_lat_reg, right_lat_next;
    logic        accept;

    assign in_stall = q_status.full;
    assign accept   = in_valid && !q_status.full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            identity_reg  <= srcd_pkg::IDENTITY_RST;
            pending_reg   <= srcd_pkg::PEND_NONE;
            pos_reg       <= 2'd0;
            first_reg     <= 8'd0;
            second_reg    <= 8'd0;
            left_lat_reg  <= 16'd0;
            right_lat_reg <= 16'd0;
        end
        else
        begin
            if (cfg_valid)
            begin
                identity_reg <= cfg_data;
            end
            pending_reg   <= pending_next;
            pos_reg       <= pos_next;
            first_reg     <= first_next;
            second_reg    <= second_next;
            left_lat_reg  <= left_lat_next;
            right_lat_reg <= right_lat_next;
        end
    end

    always_comb
    begin
        pending_next   = pending_reg;
        pos_next       = pos_reg;
        first_next     = first_reg;
        second_next    = second_reg;
        left_lat_next  = left_lat_reg;
        right_lat_next = right_lat_reg;
        push           = 1'b0;
        job            = '0;
        job.kind       = srcd_pkg::KIND_EMIT;
        if (accept)
        begin
            if (operation)
            begin
                push       = 1'b1;
                job.kind   = srcd_pkg::KIND_WRITE;
                job.arg_a  = sensor_reading;
                job.arg_b  = {3'b000, sensor_slot};
            end
            else if (pending_reg != srcd_pkg::PEND_NONE)
            begin
                case (pending_reg)
                    srcd_pkg::PEND_VELOCITY, srcd_pkg::PEND_FORWARD,
                    srcd_pkg::PEND_BACK, srcd_pkg::PEND_ROT_RIGHT,
                    srcd_pkg::PEND_ROT_LEFT:
                    begin
                        if (pos_reg == 2'd0)
                        begin
                            first_next = rx_byte;
                            pos_next   = 2'd1;
                        end
                        else
                        begin
                            pending_next = srcd_pkg::PEND_NONE;
                            pos_next     = 2'd0;
                            push         = 1'b1;
                            if (pending_reg == srcd_pkg::PEND_VELOCITY)
                            begin
                                job.action = srcd_pkg::ACT_SPEEDS;
                                job.arg_a  = first_reg;
                                job.arg_b  = rx_byte;
                            end
                            else
                            begin
                                job.action = pending_reg + srcd_pkg::PEND_TO_MOVE_ACT;
                                // first * 255 + second
                                job.amount = {first_reg, 8'h00} - {8'h00, first_reg}
                                             + {8'h00, rx_byte};
                            end
                        end
                    end
                    srcd_pkg::PEND_SERVO1, srcd_pkg::PEND_SERVO2,
                    srcd_pkg::PEND_SERVO3:
                    begin
                        pending_next = srcd_pkg::PEND_NONE;
                        pos_next     = 2'd0;
                        push         = 1'b1;
                        job.action   = srcd_pkg::ACT_SERVO;
                        job.arg_a    = {4'h0, pending_reg - srcd_pkg::PEND_TO_SERVO};
                        job.arg_b    = rx_byte;
                    end
                    srcd_pkg::PEND_LCD:
                    begin
                        if (pos_reg == 2'd0)
                        begin
                            first_next = rx_byte;
                            pos_next   = 2'd1;
                        end
                        else if (pos_reg == 2'd1)
                        begin
                            second_next = rx_byte;
                            pos_next    = 2'd2;
                        end
                        else
                        begin
                            pending_next = srcd_pkg::PEND_NONE;
                            pos_next     = 2'd0;
                            push         = 1'b1;
                            job.action   = srcd_pkg::ACT_LCD;
                            job.arg_a    = first_reg;
                            job.arg_b    = second_reg;
                            job.arg_c    = rx_byte;
                        end
                    end
                    default:
                    begin
                        pending_next = srcd_pkg::PEND_NONE;
                        pos_next     = 2'd0;
                    end
                endcase
            end
            else
            begin
                case (rx_byte)
                    srcd_pkg::CMD_FORWARD:
                    begin
                        push = 1'b1; job.action = srcd_pkg::ACT_DIRECTION;
                        job.arg_a = srcd_pkg::DIR_FORWARD;
                    end
                    srcd_pkg::CMD_BACK:
                    begin
                        push = 1'b1; job.action = srcd_pkg::ACT_DIRECTION;
                        job.arg_a = srcd_pkg::DIR_BACK;
                    end
                    srcd_pkg::CMD_RIGHT:
                    begin
                        push = 1'b1; job.action = srcd_pkg::ACT_DIRECTION;
                        job.arg_a = srcd_pkg::DIR_RIGHT;
                    end
                    srcd_pkg::CMD_LEFT:
                    begin
                        push = 1'b1; job.action = srcd_pkg::ACT_DIRECTION;
                        job.arg_a = srcd_pkg::DIR_LEFT;
                    end
                    srcd_pkg::CMD_STOP:
                    begin
                        push = 1'b1; job.action = srcd_pkg::ACT_DIRECTION;
                        job.arg_a = srcd_pkg::DIR_STOP;
                    end
                    srcd_pkg::CMD_BUZZ_ON:
                    begin
                        push = 1'b1; job.action = srcd_pkg::ACT_BUZZER;
                        job.arg_a = 8'd1;
                    end
                    srcd_pkg::CMD_BUZZ_OFF:
                    begin
                        push = 1'b1; job.action = srcd_pkg::ACT_BUZZER;
                    end
                    srcd_pkg::CMD_FULL_SPEED:
                    begin
                        push = 1'b1; job.action = srcd_pkg::ACT_SPEEDS;
                        job.arg_a = srcd_pkg::FULL_SPEED;
                        job.arg_b = srcd_pkg::FULL_SPEED;
                    end
                    srcd_pkg::CMD_IDENTITY:
                    begin
                        push = 1'b1; job.action = srcd_pkg::ACT_TX;
                        job.arg_a = identity_reg;
                    end
                    srcd_pkg::CMD_LEFT_LO:
                    begin
                        left_lat_next = left_pulses;
                        push = 1'b1; job.action = srcd_pkg::ACT_TX;
                        job.arg_a = left_pulses[7:0];
                    end
                    srcd_pkg::CMD_LEFT_HI:
                    begin
                        push = 1'b1; job.action = srcd_pkg::ACT_TX;
                        job.arg_a = left_lat_reg[15:8];
                    end
                    srcd_pkg::CMD_RIGHT_LO:
                    begin
                        right_lat_next = right_pulses;
                        push = 1'b1; job.action = srcd_pkg::ACT_TX;
                        job.arg_a = right_pulses[7:0];
                    end
                    srcd_pkg::CMD_RIGHT_HI:
                    begin
                        push = 1'b1; job.action = srcd_pkg::ACT_TX;
                        job.arg_a = right_lat_reg[15:8];
                    end
                    srcd_pkg::CMD_SENSORS:
                    begin
                        push = 1'b1; job.kind = srcd_pkg::KIND_DUMP;
                    end
                    srcd_pkg::CMD_VELOCITY:
                    begin
                        pending_next = srcd_pkg::PEND_VELOCITY; pos_next = 2'd0;
                    end
                    srcd_pkg::CMD_MOVE_FWD:
                    begin
                        pending_next = srcd_pkg::PEND_FORWARD; pos_next = 2'd0;
                    end
                    srcd_pkg::CMD_MOVE_BACK:
                    begin
                        pending_next = srcd_pkg::PEND_BACK; pos_next = 2'd0;
                    end
                    srcd_pkg::CMD_ROT_RIGHT:
                    begin
                        pending_next = srcd_pkg::PEND_ROT_RIGHT; pos_next = 2'd0;
                    end
                    srcd_pkg::CMD_ROT_LEFT:
                    begin
                        pending_next = srcd_pkg::PEND_ROT_LEFT; pos_next = 2'd0;
                    end
                    srcd_pkg::CMD_SERVO1:
                    begin
                        pending_next = srcd_pkg::PEND_SERVO1; pos_next = 2'd0;
                    end
                    srcd_pkg::CMD_SERVO2:
                    begin
                        pending_next = srcd_pkg::PEND_SERVO2; pos_next = 2'd0;
                    end
                    srcd_pkg::CMD_SERVO3:
                    begin
                        pending_next = srcd_pkg::PEND_SERVO3; pos_next = 2'd0;
                    end
                    srcd_pkg::CMD_LCD:
                    begin
                        pending_next = srcd_pkg::PEND_LCD; pos_next = 2'd0;
                    end
                    default:
                    begin
                        push = 1'b0;
                    end
                endcase
            end
        end
    end

endmodule

### rtl/srcd_queue.sv
module srcd_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  srcd_pkg::job_t       push_job,
    input  logic                 pop,
    output srcd_pkg::job_t       head_job,
    output srcd_pkg::q_status_t  q_status
);

    srcd_pkg::job_t              slot_reg [srcd_pkg::QUEUE_DEPTH];
    logic [srcd_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [srcd_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [srcd_pkg::QPTR_W:0]   count_reg;
    logic                        do_push;
    logic                        do_pop;

    assign q_status.full  = (count_reg == (srcd_pkg::QPTR_W + 1)'(srcd_pkg::QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign do_push        = push && !q_status.full;
    assign do_pop         = pop && !q_status.empty;
    assign head_job       = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

### rtl/srcd_back.sv
module srcd_back
#(
    parameter int SENSOR_COUNT = 17
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  srcd_pkg::job_t       head_job,
    input  srcd_pkg::q_status_t  q_status,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [3:0]           action,
    output logic [7:0]           arg_a,
    output logic [7:0]           arg_b,
    output logic [7:0]           arg_c,
    output logic [15:0]          amount,
    output logic                 last
);

    localparam int CW = $clog2(SENSOR_COUNT + 2);
    localparam int IW = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DUMP = 1'b1;

    logic [7:0]    table_reg [SENSOR_COUNT];
    logic          state_reg, state_next;
    logic [CW-1:0] cnt_reg,   cnt_next;
    logic          out_valid_reg;
    logic [3:0]    action_reg;
    logic [7:0]    arg_a_reg;
    logic [7:0]    arg_b_reg;
    logic [7:0]    arg_c_reg;
    logic [15:0]   amount_reg;
    logic          last_reg;

    logic          room;
    logic          load;
    logic [3:0]    action_next;
    logic [7:0]    arg_a_next;
    logic [7:0]    arg_b_next;
    logic [7:0]    arg_c_next;
    logic [15:0]   amount_next;
    logic          last_next;
    logic          tbl_we;
    logic [IW-1:0] rd_idx;
    logic [IW-1:0] wr_idx;
    logic          slot_ok;

    assign room    = !out_valid_reg || !out_stall;
    assign rd_idx  = IW'(cnt_reg - CW'(1));
    assign wr_idx  = head_job.arg_b[IW-1:0];
    assign slot_ok = ({1'b0, head_job.arg_b} < 9'(SENSOR_COUNT));

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        pop         = 1'b0;
        load        = 1'b0;
        tbl_we      = 1'b0;
        action_next = srcd_pkg::ACT_TX;
        arg_a_next  = 8'd0;
        arg_b_next  = 8'd0;
        arg_c_next  = 8'd0;
        amount_next = 16'd0;
        last_next   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    case (head_job.kind)
                        srcd_pkg::KIND_WRITE:
                        begin
                            // table writes never wait on the output side
                            pop    = 1'b1;
                            tbl_we = slot_ok;
                        end
                        srcd_pkg::KIND_DUMP:
                        begin
                            if (room)
                            begin
                                load       = 1'b1;
                                arg_a_next = srcd_pkg::FRAME_START;
                                cnt_next   = CW'(1);
                                state_next = ST_DUMP;
                            end
                        end
                        default:
                        begin
                            if (room)
                            begin
                                pop         = 1'b1;
                                load        = 1'b1;
                                action_next = head_job.action;
                                arg_a_next  = head_job.arg_a;
                                arg_b_next  = head_job.arg_b;
                                arg_c_next  = head_job.arg_c;
                                amount_next = head_job.amount;
                                last_next   = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_DUMP:
            begin
                if (room)
                begin
                    load = 1'b1;
                    if (cnt_reg == CW'(SENSOR_COUNT + 1))
                    begin
                        // closing frame byte ends the dump
                        arg_a_next = srcd_pkg::FRAME_END;
                        last_next  = 1'b1;
                        pop        = 1'b1;
                        cnt_next   = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        arg_a_next = table_reg[rd_idx];
                        cnt_next   = cnt_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SENSOR_COUNT; i++)
            begin
                table_reg[i] <= 8'd0;
            end
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (tbl_we)
            begin
                table_reg[wr_idx] <= head_job.arg_a;
            end
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (room)
            begin
                out_valid_reg <= load;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            action_reg <= action_next;
            arg_a_reg  <= arg_a_next;
            arg_b_reg  <= arg_b_next;
            arg_c_reg  <= arg_c_next;
            amount_reg <= amount_next;
            last_reg   <= last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign action    = action_reg;
    assign arg_a     = arg_a_reg;
    assign arg_b     = arg_b_reg;
    assign arg_c     = arg_c_reg;
    assign amount    = amount_reg;
    assign last      = last_reg;

endmodule

### rtl/serial_robot_command_decoder_unit.sv
// Path: a single-result command passes the job queue, then the output register.
// Throughput: one request per cycle into a four-entry job queue while in_stall is low;
// with output room the executor drains one single-result job or table write per cycle,
// and a sensor dump holds it for SENSOR_COUNT + 2 bytes (19 by default), one per cycle.
// Reset: asynchronous, clears sequence state, latched counts and the sensor table at once,
// and sets the identity byte to 5; no clearing pass.
module serial_robot_command_decoder_unit
#(
    parameter int SENSOR_COUNT = 17
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [7:0]  rx_byte,
    input  logic [4:0]  sensor_slot,
    input  logic [7:0]  sensor_reading,
    input  logic [15:0] left_pulses,
    input  logic [15:0] right_pulses,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  action,
    output logic [7:0]  arg_a,
    output logic [7:0]  arg_b,
    output logic [7:0]  arg_c,
    output logic [15:0] amount,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    srcd_pkg::job_t      push_job;
    srcd_pkg::job_t      head_job;
    srcd_pkg::q_status_t q_status;
    logic                push;
    logic                pop;

    assign cfg_ready = 1'b1;

    srcd_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .rx_byte        (rx_byte),
        .sensor_slot    (sensor_slot),
        .sensor_reading (sensor_reading),
        .left_pulses    (left_pulses),
        .right_pulses   (right_pulses),
        .cfg_valid      (cfg_valid),
        .cfg_data       (cfg_data),
        .q_status       (q_status),
        .push           (push),
        .job            (push_job)
    );

    srcd_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .q_status (q_status)
    );

    srcd_back #(.SENSOR_COUNT(SENSOR_COUNT)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_job  (head_job),
        .q_status  (q_status),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .action    (action),
        .arg_a     (arg_a),
        .arg_b     (arg_b),
        .arg_c     (arg_c),
        .amount    (amount),
        .last      (last)
    );

endmodule
